>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clock, masked during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define AST_HOLD(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define AST_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lkv_pkg.sv
// ---------------------------------------------------------------------------
// lkv_pkg
// Shared constants, codes and cell control types for the LRU key-value cache.
// ---------------------------------------------------------------------------
package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int DATA_W  = 32;
   localparam int CSR_W   = 5;
   localparam int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W = $clog2(ENTRIES + 1);
   localparam int CAP_W   = (COUNT_W > CSR_W) ? COUNT_W : CSR_W;

   localparam logic [CSR_W-1:0]  CAPACITY_RESET = CSR_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE     = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } lkv_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_TOUCH,
      OP_FILL,
      OP_REPLACE,
      OP_BYPASS
   } lkv_op_type;

   typedef struct packed {
      logic              load_match;
      logic              commit;
      lkv_op_type        op;
      logic              is_put;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [RANK_W-1:0] hit_rank;
      logic [RANK_W-1:0] victim_rank;
   } lkv_cmd_type;

   typedef struct packed {
      logic              valid;
      logic              match;
      logic              victim;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [RANK_W-1:0] rank;
   } lkv_status_type;

endpackage

>>> rtl/core/lkv_req_if.sv
// ---------------------------------------------------------------------------
// lkv_req_if
// Request channel: get or put item with key and value.
// ---------------------------------------------------------------------------
interface lkv_req_if;
   import lkv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic signed [DATA_W-1:0] lookup_key;
   logic signed [DATA_W-1:0] write_value;

   modport source (output valid, output cmd, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input cmd, input lookup_key, input write_value,
                   output ready);
endinterface

>>> rtl/core/lkv_rsp_if.sv
// ---------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: hit flag, read value and eviction report.
// ---------------------------------------------------------------------------
interface lkv_rsp_if;
   import lkv_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [DATA_W-1:0] read_value;
   logic                     evicted;
   logic signed [DATA_W-1:0] evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

>>> rtl/core/lkv_cell.sv
// ---------------------------------------------------------------------------
// lkv_cell
// One cache entry: key, value, valid mark and recency rank. Compares the
// broadcast key, applies the committed operation and passes the free-slot
// token on to its neighbour.
// ---------------------------------------------------------------------------
module lkv_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lkv_pkg::lkv_cmd_type   cmd,
   input  logic                   prior_free,
   output logic                   chain_free,
   output lkv_pkg::lkv_status_type status
);
   import lkv_pkg::*;

   logic              valid_ff, valid_in;
   logic              match_ff, match_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              first_free;
   logic              victim;

   assign first_free = !valid_ff && !prior_free;
   assign chain_free = prior_free || !valid_ff;
   assign victim     = valid_ff && (rank_ff == cmd.victim_rank);

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      rank_in  = rank_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (cmd.load_match) begin
         match_in = valid_ff && (key_ff == cmd.key);
      end
      if (cmd.commit) begin
         case (cmd.op)
            OP_TOUCH: begin
               if (match_ff) begin
                  rank_in = '0;
                  if (cmd.is_put) begin
                     value_in = cmd.value;
                  end
               end else if (valid_ff && (rank_ff < cmd.hit_rank)) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            OP_FILL: begin
               if (first_free) begin
                  valid_in = 1'b1;
                  rank_in  = '0;
                  key_in   = cmd.key;
                  value_in = cmd.value;
               end else if (valid_ff) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            OP_REPLACE: begin
               if (victim) begin
                  rank_in  = '0;
                  key_in   = cmd.key;
                  value_in = cmd.value;
               end else if (valid_ff) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign status.valid  = valid_ff;
   assign status.match  = match_ff;
   assign status.victim = victim;
   assign status.key    = key_ff;
   assign status.value  = value_ff;
   assign status.rank   = rank_ff;

endmodule

>>> rtl/core/lru_key_value_cache_unit.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least recently used replacement,
// built as a row of entry cells under a small sequencer.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  req_chan | in  | valid / ready | cmd, lookup_key, write_value
//  rsp_chan | out | valid / ready | hit, read_value, evicted, evicted_key
//  csr      | in  | write enable  | capacity_in_use (5 bits)
//
//  Each item is handled as a key compare in every cell, then the commit of
//  value and recency ranks across the row; each cell registers its compare.
//  The next item is taken in the commit cycle. Reset clears valid marks,
//  ranks and the entry count. A stalled response holds the commit; one
//  finished item may wait in the output register while the next is compared.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lru_key_value_cache_unit (
   input  logic                      clock,
   input  logic                      reset,
   lkv_req_if.sink                   req_chan,
   lkv_rsp_if.source                 rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [lkv_pkg::CSR_W-1:0] csr_write_data
);
   import lkv_pkg::*;

   lkv_state_type     state_ff, state_in;
   logic [CSR_W-1:0]  capacity_ff;
   logic [COUNT_W-1:0] count_ff;
   logic              req_put_ff;
   logic [DATA_W-1:0] req_key_ff;
   logic [DATA_W-1:0] req_value_ff;

   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [DATA_W-1:0] rsp_read_ff;
   logic              rsp_evicted_ff;
   logic [DATA_W-1:0] rsp_evkey_ff;

   lkv_cmd_type       cell_cmd;
   lkv_status_type    cell_status [ENTRIES];
   logic [ENTRIES:0]  free_chain;
   logic [ENTRIES-1:0] valid_vec;
   logic [ENTRIES-1:0] match_vec;

   logic              accept;
   logic              rsp_free;
   logic              commit;
   logic              any_hit;
   logic [RANK_W-1:0] hit_rank;
   logic [DATA_W-1:0] hit_value;
   logic [DATA_W-1:0] victim_key;
   logic [CAP_W-1:0]  cap_ext;
   logic [CAP_W-1:0]  cap_eff;
   logic              over_cap;
   lkv_op_type        op_sel;

   // ---------------- cell row ----------------
   assign free_chain[0] = 1'b0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .prior_free (free_chain[g]),
         .chain_free (free_chain[g+1]),
         .status     (cell_status[g])
      );
      assign valid_vec[g] = cell_status[g].valid;
      assign match_vec[g] = cell_status[g].match;
   end

   always_comb begin
      hit_rank   = '0;
      hit_value  = '0;
      victim_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (cell_status[i].match) begin
            hit_rank  = hit_rank | cell_status[i].rank;
            hit_value = hit_value | cell_status[i].value;
         end
         if (cell_status[i].victim) begin
            victim_key = victim_key | cell_status[i].key;
         end
      end
   end

   assign any_hit = |match_vec;

   // ---------------- decision ----------------
   assign cap_ext  = CAP_W'(capacity_ff);
   assign cap_eff  = (cap_ext > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_ext;
   assign over_cap = ({1'b0, CAP_W'(count_ff)} + 1'b1) > {1'b0, cap_eff};

   always_comb begin
      if (any_hit) begin
         op_sel = OP_TOUCH;
      end else if (!req_put_ff) begin
         op_sel = OP_NONE;
      end else if (!over_cap) begin
         op_sel = OP_FILL;
      end else if (count_ff != '0) begin
         op_sel = OP_REPLACE;
      end else begin
         op_sel = OP_BYPASS;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign commit   = (state_ff == ST_UPDATE) && rsp_free;

   assign cell_cmd.load_match  = (state_ff == ST_MATCH);
   assign cell_cmd.commit      = commit;
   assign cell_cmd.op          = op_sel;
   assign cell_cmd.is_put      = req_put_ff;
   assign cell_cmd.key         = req_key_ff;
   assign cell_cmd.value       = req_value_ff;
   assign cell_cmd.hit_rank    = hit_rank;
   assign cell_cmd.victim_rank = RANK_W'(count_ff - 1'b1);

   // ---------------- sequencer ----------------
   assign req_chan.ready = (state_ff == ST_IDLE) || commit;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (commit) begin
               state_in = accept ? ST_MATCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         capacity_ff  <= CAPACITY_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (commit && (op_sel == OP_FILL)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_put_ff   <= req_chan.cmd;
         req_key_ff   <= req_chan.lookup_key;
         req_value_ff <= req_chan.write_value;
      end
      if (commit) begin
         rsp_hit_ff     <= any_hit;
         rsp_read_ff    <= req_put_ff ? '0 : (any_hit ? hit_value : MISS_VALUE);
         rsp_evicted_ff <= (op_sel == OP_REPLACE) || (op_sel == OP_BYPASS);
         rsp_evkey_ff   <= (op_sel == OP_REPLACE) ? victim_key :
                           (op_sel == OP_BYPASS)  ? req_key_ff : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.read_value  = rsp_read_ff;
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

   // ---------------- assertions ----------------
   `AST_HOLD(a_count_tracks_valid, $countones(valid_vec) == 32'(count_ff),
             "entry count differs from valid marks")
   `AST_HOLD(a_unique_match, $onehot0(match_vec), "key matched in more than one entry")
   `AST_HOLD(a_fill_has_slot, !(commit && (op_sel == OP_FILL)) || free_chain[ENTRIES],
             "fill with no free entry")
   `AST_NEXT(a_match_then_update, state_ff == ST_MATCH, state_ff == ST_UPDATE,
             "compare not followed by commit stage")
   `AST_NEXT(a_commit_gives_rsp, commit, rsp_valid_ff, "commit without response")

endmodule

>>> dv/lru_key_value_cache_unit_test.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit_test
// Self-checking bench for the LRU key-value cache. Get and put items are sent
// under random idling and response stalls; a cycle-free model of the cache
// predicts hit, read value and eviction for every item, and each response is
// compared in order. Capacity is changed between phases while the block is
// idle, covering zero, saturation above the entry count and shrinking.
// ---------------------------------------------------------------------------
module lru_key_value_cache_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lkv_pkg::*;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_CYCLES    = 8;
   localparam int QUIET_LIMIT     = 1000;
   localparam int ITEMS_PER_PHASE = 75;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
      logic [DATA_W-1:0] evicted_key;
   } cache_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_write_enable;
   logic [CSR_W-1:0]  csr_write_data;

   lkv_req_if req_chan ();
   lkv_rsp_if rsp_chan ();

   lru_key_value_cache_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // cache model state
   logic [DATA_W-1:0] model_key   [ENTRIES];
   logic [DATA_W-1:0] model_value [ENTRIES];
   logic              model_valid [ENTRIES];
   int unsigned       model_rank  [ENTRIES];
   int                model_count;
   logic [CSR_W-1:0]  model_capacity;

   cache_result_type  pending_outcomes [$];
   cache_result_type  oldest_outcome;
   logic [DATA_W-1:0] key_pool [$];
   int                mismatch_count = 0;
   int                quiet_cycles   = 0;
   int                rsp_stall_left = 0;
   logic              req_idle_enable  = 1'b1;
   logic              rsp_stall_enable = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic void clear_cache_model();
      for (int i = 0; i < ENTRIES; i++) begin
         model_valid[i] = 1'b0;
         model_rank[i]  = 0;
      end
      model_count    = 0;
      model_capacity = CAPACITY_RESET;
   endfunction

   function automatic cache_result_type cache_access_outcome(input logic cmd,
                                                             input logic [DATA_W-1:0] key,
                                                             input logic [DATA_W-1:0] value);
      cache_result_type outcome;
      int            found;
      int            slot;
      int            limit;
      int unsigned   old_rank;
      outcome = '0;
      limit   = (model_capacity > ENTRIES) ? ENTRIES : int'(model_capacity);
      found   = -1;
      slot    = -1;
      for (int i = 0; i < ENTRIES; i++)
         if (found < 0 && model_valid[i] && model_key[i] == key) found = i;
      if (found >= 0) begin
         outcome.hit = 1'b1;
         if (cmd == CMD_PUT) model_value[found] = value;
         else outcome.read_value = model_value[found];
         old_rank = model_rank[found];
         for (int i = 0; i < ENTRIES; i++)
            if (model_valid[i] && model_rank[i] < old_rank) model_rank[i]++;
         model_rank[found] = 0;
      end else if (cmd == CMD_GET) begin
         outcome.read_value = MISS_VALUE;
      end else if (model_count == 0 && limit == 0) begin
         // nothing may be held: the new key is dropped at once
         outcome.evicted     = 1'b1;
         outcome.evicted_key = key;
      end else begin
         if (model_count + 1 > limit) begin
            for (int i = 0; i < ENTRIES; i++)
               if (model_valid[i] && (slot < 0 || model_rank[i] > model_rank[slot])) slot = i;
            if (slot >= 0) begin
               outcome.evicted     = 1'b1;
               outcome.evicted_key = model_key[slot];
               model_valid[slot]   = 1'b0;
               model_count--;
            end
         end
         if (slot < 0)
            for (int i = 0; i < ENTRIES; i++)
               if (slot < 0 && !model_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
               if (model_valid[i]) model_rank[i]++;
            model_key[slot]   = key;
            model_value[slot] = value;
            model_valid[slot] = 1'b1;
            model_rank[slot]  = 0;
            model_count++;
         end
      end
      return outcome;
   endfunction

   // valid is left high after acceptance, so back-to-back items keep it asserted with no drop in between
   task automatic send_access(input logic cmd, input logic [DATA_W-1:0] key,
                              input logic [DATA_W-1:0] value);
      int gap;
      gap = req_idle_enable ? pick_gap() : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.cmd         <= cmd;
      req_chan.lookup_key  <= key;
      req_chan.write_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      pending_outcomes.push_back(cache_access_outcome(cmd, key, value));
   endtask

   task automatic set_capacity(input logic [CSR_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_capacity = value;
   endtask

   task automatic test_zero_capacity_bypass();
      set_capacity(5'd0);
      send_access(CMD_PUT, 32'h1234_5678, 32'hCAFE_0001);
      send_access(CMD_GET, 32'h1234_5678, $urandom);
   endtask

   task automatic test_field_extremes();
      set_capacity(5'd31);
      send_access(CMD_GET, 32'h0000_0000, $urandom);
      send_access(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_access(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_access(CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_access(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      send_access(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_access(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_access(CMD_PUT, 32'h7FFF_FFFF, 32'h5555_5555);
      send_access(CMD_GET, 32'h7FFF_FFFF, $urandom);
      send_access(CMD_PUT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
   endtask

   // capacity dropped below the held count: each new key replaces the oldest
   task automatic test_capacity_shrink();
      set_capacity(5'd2);
      send_access(CMD_GET, 32'h8000_0000, $urandom);
      send_access(CMD_PUT, 32'h0000_0001, 32'h0000_0011);
      send_access(CMD_PUT, 32'h0000_0002, 32'h0000_0022);
      send_access(CMD_GET, 32'h0000_0000, $urandom);
      send_access(CMD_PUT, 32'h0000_0003, 32'h0000_0033);
      send_access(CMD_GET, 32'h0000_0001, $urandom);
   endtask

   task automatic test_random_traffic();
      logic [CSR_W-1:0]  capacity_plan [7];
      logic              cmd;
      logic [DATA_W-1:0] key;
      int                held;
      capacity_plan = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd9, 5'd17};
      for (int phase = 0; phase < 7; phase++) begin
         set_capacity(capacity_plan[phase]);
         req_idle_enable  = (phase != 2);
         rsp_stall_enable = (phase != 2);
         held = (capacity_plan[phase] > ENTRIES) ? ENTRIES : int'(capacity_plan[phase]);
         key_pool.delete();
         repeat ($urandom_range(2, held + 4)) begin
            case ($urandom_range(0, 7))
               0:       key_pool.push_back(32'h8000_0000);
               1:       key_pool.push_back(32'h7FFF_FFFF);
               default: key_pool.push_back($urandom);
            endcase
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_PUT : CMD_GET;
            key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                            : $urandom;
            send_access(cmd, key, $urandom);
         end
      end
      req_idle_enable  = 1'b1;
      rsp_stall_enable = 1'b1;
   endtask

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (rsp_stall_enable && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = pick_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response item with no outstanding request");
            mismatch_count++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_chan.hit !== oldest_outcome.hit) begin
               $error("hit: expected %0b, actual %0b", oldest_outcome.hit, rsp_chan.hit);
               mismatch_count++;
            end
            if (rsp_chan.read_value !== oldest_outcome.read_value) begin
               $error("read_value: expected %h, actual %h",
                      oldest_outcome.read_value, rsp_chan.read_value);
               mismatch_count++;
            end
            if (rsp_chan.evicted !== oldest_outcome.evicted) begin
               $error("evicted: expected %0b, actual %0b",
                      oldest_outcome.evicted, rsp_chan.evicted);
               mismatch_count++;
            end
            if (rsp_chan.evicted_key !== oldest_outcome.evicted_key) begin
               $error("evicted_key: expected %h, actual %h",
                      oldest_outcome.evicted_key, rsp_chan.evicted_key);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_write_enable     = 1'b0;
      csr_write_data       = '0;
      req_chan.valid       = 1'b0;
      req_chan.cmd         = CMD_GET;
      req_chan.lookup_key  = '0;
      req_chan.write_value = '0;
      rsp_chan.ready       = 1'b0;
      clear_cache_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_zero_capacity_bypass();
      test_field_extremes();
      test_capacity_shrink();
      test_random_traffic();

      req_chan.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lkv_pkg.sv
rtl/core/lkv_req_if.sv
rtl/core/lkv_rsp_if.sv
rtl/core/lkv_cell.sv
rtl/core/lru_key_value_cache_unit.sv
dv/lru_key_value_cache_unit_test.sv
